### rtl/jfsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG frame size parser package
// Shared types and constants: parse phases, status codes and header bytes.
// ----------------------------------------------------------------------------
package jfsp_pkg;

   typedef enum logic [7:0] {
      PH_HEADER = 8'b0000_0001,
      PH_SKIP   = 8'b0000_0010,
      PH_MARK0  = 8'b0000_0100,
      PH_MARK1  = 8'b0000_1000,
      PH_LENHI  = 8'b0001_0000,
      PH_LENLO  = 8'b0010_0000,
      PH_FRAME  = 8'b0100_0000,
      PH_DONE   = 8'b1000_0000
   } phase_type;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_FOUND     = 2'd0;
   localparam status_type STATUS_INVALID   = 2'd1;
   localparam status_type STATUS_NOT_FOUND = 2'd2;

   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [7:0] MARKER_SOI    = 8'hD8;
   localparam logic [7:0] MARKER_APP0   = 8'hE0;
   localparam logic [7:0] MARKER_SOF0   = 8'hC0;

   localparam logic [3:0] HDR_LEN_HI   = 4'd4;
   localparam logic [3:0] HDR_LEN_LO   = 4'd5;
   localparam logic [3:0] HDR_LAST     = 4'd10;
   localparam logic [3:0] SOF_HEIGHT_HI = 4'd5;
   localparam logic [3:0] SOF_HEIGHT_LO = 4'd6;
   localparam logic [3:0] SOF_WIDTH_HI  = 4'd7;
   localparam logic [3:0] SOF_WIDTH_LO  = 4'd8;
   localparam logic [3:0] SOF_START     = 4'd2;

   localparam logic [15:0] APP0_MIN_LEN = 16'd7;
   localparam logic [15:0] SEG_MIN_LEN  = 16'd2;

   // Expected byte at each header position; the length bytes are not compared.
   function automatic logic [7:0] header_byte(input logic [3:0] offset);
      logic [7:0] value;
      unique case (offset)
         4'd0:    value = MARKER_PREFIX;
         4'd1:    value = MARKER_SOI;
         4'd2:    value = MARKER_PREFIX;
         4'd3:    value = MARKER_APP0;
         4'd6:    value = 8'h4A;
         4'd7:    value = 8'h46;
         4'd8:    value = 8'h49;
         4'd9:    value = 8'h46;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

### rtl/jfsp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG frame size parser input channel
// Valid/ready channel that carries one file byte and its end-of-file flag.
// ----------------------------------------------------------------------------
interface jfsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/jfsp_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG frame size parser result channel
// Valid/ready channel that carries the status and frame size of one file.
// ----------------------------------------------------------------------------
interface jfsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] image_height;
   logic [15:0] image_width;

   modport source (output valid, output status, output image_height, output image_width,
                   input ready);
   modport sink   (input valid, input status, input image_height, input image_width,
                   output ready);
endinterface

### rtl/jpeg_frame_size_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG frame size parser
// Walks the bytes of a JPEG file and reports the baseline frame size once.
// ----------------------------------------------------------------------------
// The parser takes one byte per cycle and reports one result per file: the
// height and width from the baseline frame marker, an invalid format status,
// or a not found status when the last byte arrives first. Each byte updates
// the parse state in the cycle of its transfer, and its result is held in an
// output register from the next cycle. A new byte is taken while that
// register is empty or is being emptied, so the rate is one byte per cycle
// for as long as the result side keeps up.
module jpeg_frame_size_parser (
   input logic         clock,
   input logic         reset,
   jfsp_req_if.sink    req_ch,
   jfsp_rsp_if.source  rsp_ch
);

   jfsp_pkg::phase_type  phase_ff, phase_in;
   logic [3:0]           offset_ff, offset_in;
   logic [15:0]          seglen_ff, seglen_in;
   logic [15:0]          skip_ff, skip_in;
   logic [15:0]          height_ff, height_in;

   logic                 rsp_valid_ff;
   jfsp_pkg::status_type rsp_status_ff;
   logic [15:0]          rsp_height_ff;
   logic [15:0]          rsp_width_ff;

   logic                 accept;
   logic                 found;
   logic                 invalid;
   logic                 res_valid;
   jfsp_pkg::status_type res_status;
   logic [15:0]          res_height;
   logic [15:0]          res_width;
   logic [7:0]           b;
   logic [15:0]          count;

   assign b      = req_ch.data_byte;
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      phase_in   = phase_ff;
      offset_in  = offset_ff;
      seglen_in  = seglen_ff;
      skip_in    = skip_ff;
      height_in  = height_ff;
      found      = 1'b0;
      invalid    = 1'b0;
      count      = 16'd0;
      res_valid  = 1'b0;
      res_status = jfsp_pkg::STATUS_NOT_FOUND;
      res_height = 16'd0;
      res_width  = 16'd0;

      unique case (phase_ff)
         jfsp_pkg::PH_HEADER: begin
            if (offset_ff == jfsp_pkg::HDR_LEN_HI) begin
               seglen_in = {b, 8'h00};
            end else if (offset_ff == jfsp_pkg::HDR_LEN_LO) begin
               seglen_in = {seglen_ff[15:8], b};
            end else if (b != jfsp_pkg::header_byte(offset_ff)) begin
               invalid = 1'b1;
            end
            if (!invalid) begin
               if (offset_ff == jfsp_pkg::HDR_LAST) begin
                  if (seglen_ff < jfsp_pkg::APP0_MIN_LEN) begin
                     invalid = 1'b1;
                  end else begin
                     count    = seglen_ff - jfsp_pkg::APP0_MIN_LEN;
                     skip_in  = count;
                     phase_in = (count != 16'd0) ? jfsp_pkg::PH_SKIP : jfsp_pkg::PH_MARK0;
                  end
               end else begin
                  offset_in = offset_ff + 4'd1;
               end
            end
         end
         jfsp_pkg::PH_SKIP: begin
            skip_in = skip_ff - 16'd1;
            if (skip_ff == 16'd1) begin
               phase_in = jfsp_pkg::PH_MARK0;
            end
         end
         jfsp_pkg::PH_MARK0: begin
            if (b != jfsp_pkg::MARKER_PREFIX) begin
               invalid = 1'b1;
            end else begin
               phase_in = jfsp_pkg::PH_MARK1;
            end
         end
         jfsp_pkg::PH_MARK1: begin
            if (b == jfsp_pkg::MARKER_SOF0) begin
               phase_in  = jfsp_pkg::PH_FRAME;
               offset_in = jfsp_pkg::SOF_START;
            end else begin
               phase_in = jfsp_pkg::PH_LENHI;
            end
         end
         jfsp_pkg::PH_LENHI: begin
            seglen_in = {b, 8'h00};
            phase_in  = jfsp_pkg::PH_LENLO;
         end
         jfsp_pkg::PH_LENLO: begin
            seglen_in = {seglen_ff[15:8], b};
            if (seglen_in < jfsp_pkg::SEG_MIN_LEN) begin
               invalid = 1'b1;
            end else begin
               count    = seglen_in - jfsp_pkg::SEG_MIN_LEN;
               skip_in  = count;
               phase_in = (count != 16'd0) ? jfsp_pkg::PH_SKIP : jfsp_pkg::PH_MARK0;
            end
         end
         jfsp_pkg::PH_FRAME: begin
            if (offset_ff == jfsp_pkg::SOF_HEIGHT_HI) begin
               height_in = {b, 8'h00};
            end else if (offset_ff == jfsp_pkg::SOF_HEIGHT_LO) begin
               height_in = {height_ff[15:8], b};
            end else if (offset_ff == jfsp_pkg::SOF_WIDTH_HI) begin
               seglen_in = {b, 8'h00};
            end else if (offset_ff >= jfsp_pkg::SOF_WIDTH_LO) begin
               found = 1'b1;
            end
            if (!found) begin
               offset_in = offset_ff + 4'd1;
            end
         end
         jfsp_pkg::PH_DONE: begin
         end
         default: begin
         end
      endcase

      if (found || invalid) begin
         phase_in   = jfsp_pkg::PH_DONE;
         res_valid  = 1'b1;
         res_status = found ? jfsp_pkg::STATUS_FOUND : jfsp_pkg::STATUS_INVALID;
         res_height = found ? height_ff : 16'd0;
         res_width  = found ? {seglen_ff[15:8], b} : 16'd0;
      end else if (req_ch.last_byte && (phase_ff != jfsp_pkg::PH_DONE)) begin
         res_valid  = 1'b1;
         res_status = jfsp_pkg::STATUS_NOT_FOUND;
      end

      if (req_ch.last_byte) begin
         phase_in  = jfsp_pkg::PH_HEADER;
         offset_in = 4'd0;
         seglen_in = 16'd0;
         skip_in   = 16'd0;
         height_in = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= jfsp_pkg::PH_HEADER;
         offset_ff <= 4'd0;
         seglen_ff <= 16'd0;
         skip_ff   <= 16'd0;
         height_ff <= 16'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         seglen_ff <= seglen_in;
         skip_ff   <= skip_in;
         height_ff <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         rsp_status_ff <= res_status;
         rsp_height_ff <= res_height;
         rsp_width_ff  <= res_width;
      end
   end

   assign req_ch.ready        = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.image_height = rsp_height_ff;
   assign rsp_ch.image_width  = rsp_width_ff;

   // A result never carries the unused status code.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff <= jfsp_pkg::STATUS_NOT_FOUND))
      else $error("result status code out of range");

   // Only a found frame reports a size.
   a_size_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != jfsp_pkg::STATUS_FOUND))
         |-> ((rsp_height_ff == 16'd0) && (rsp_width_ff == 16'd0)))
      else $error("size reported without a found frame");

   // The last byte of a file returns the parser to the header check.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.last_byte)
         |=> ((phase_ff == jfsp_pkg::PH_HEADER) && (offset_ff == 4'd0)))
      else $error("parser did not restart after the last byte");

   // The header offset never runs past the identifier.
   a_header_offset: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == jfsp_pkg::PH_HEADER) |-> (offset_ff <= jfsp_pkg::HDR_LAST))
      else $error("header offset out of range");

   // A byte after the decision, other than the last, gives no result.
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == jfsp_pkg::PH_DONE) && !req_ch.last_byte) |-> !res_valid)
      else $error("result after the decision");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG frame size parser testbench
// Streams whole, truncated and corrupted JPEG byte sequences through the
// parser with random gaps on both channels. A model of the parse walk in the
// bench predicts the status and frame size of each file, and every result
// transfer is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int RANDOM_BYTES   = 550;
   localparam int RANDOM_RESULTS = 16;
   localparam int HOLD_CYCLES    = 64;

   localparam logic [7:0] MARKER_DQT  = 8'hDB;
   localparam logic [7:0] MARKER_DHT  = 8'hC4;
   localparam logic [7:0] MARKER_APP1 = 8'hE1;

   localparam logic [87:0] JFIF_PREFIX = {jfsp_pkg::MARKER_PREFIX, jfsp_pkg::MARKER_SOI,
                                          jfsp_pkg::MARKER_PREFIX, jfsp_pkg::MARKER_APP0,
                                          16'h0000, "JFIF", 8'h00};

   typedef struct packed {
      jfsp_pkg::status_type status;
      logic [15:0]          height;
      logic [15:0]          width;
   } frame_size_type;

   logic clock;
   logic reset;

   jfsp_req_if req_bus ();
   jfsp_rsp_if rsp_bus ();

   jpeg_frame_size_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   jfsp_pkg::phase_type parse_state;
   logic [3:0]          field_pos;
   logic [15:0]         length_word;
   logic [15:0]         bytes_to_skip;
   logic [15:0]         height_word;
   logic                file_decided;

   frame_size_type expected_sizes[$];
   logic [7:0]     file_bytes[$];
   frame_size_type want;

   int req_max_gap;
   int rsp_max_gap;
   int rsp_wait;
   int hold_request;
   int hold_left;
   int error_count;
   int cycle_count;
   int bytes_sent;
   int results_seen;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic void clear_parse_state();
      parse_state   = jfsp_pkg::PH_HEADER;
      field_pos     = '0;
      length_word   = '0;
      bytes_to_skip = '0;
      height_word   = '0;
      file_decided  = 1'b0;
   endfunction

   function automatic void enter_skip(input logic [15:0] count);
      bytes_to_skip = count;
      parse_state   = (count != 16'd0) ? jfsp_pkg::PH_SKIP : jfsp_pkg::PH_MARK0;
   endfunction

   function automatic void predict_frame_size(input logic [7:0] data, input logic last);
      logic [3:0]     pos;
      logic           found;
      logic           bad;
      logic [15:0]    width_word;
      frame_size_type outcome;
      found      = 1'b0;
      bad        = 1'b0;
      width_word = '0;
      outcome    = '0;
      case (parse_state)
         jfsp_pkg::PH_HEADER: begin
            pos = (field_pos > jfsp_pkg::HDR_LAST) ? jfsp_pkg::HDR_LAST : field_pos;
            if (pos == jfsp_pkg::HDR_LEN_HI) begin
               length_word = {data, 8'h00};
            end else if (pos == jfsp_pkg::HDR_LEN_LO) begin
               length_word = length_word | {8'h00, data};
            end else if (data != JFIF_PREFIX[87 - 8 * int'(pos) -: 8]) begin
               bad = 1'b1;
            end
            if (!bad) begin
               if (pos == jfsp_pkg::HDR_LAST) begin
                  if (length_word < jfsp_pkg::APP0_MIN_LEN) begin
                     bad = 1'b1;
                  end else begin
                     enter_skip(length_word - jfsp_pkg::APP0_MIN_LEN);
                  end
               end else begin
                  field_pos = pos + 4'd1;
               end
            end
         end
         jfsp_pkg::PH_SKIP: begin
            bytes_to_skip = bytes_to_skip - 16'd1;
            if (bytes_to_skip == 16'd0) begin
               parse_state = jfsp_pkg::PH_MARK0;
            end
         end
         jfsp_pkg::PH_MARK0: begin
            if (data != jfsp_pkg::MARKER_PREFIX) begin
               bad = 1'b1;
            end else begin
               parse_state = jfsp_pkg::PH_MARK1;
            end
         end
         jfsp_pkg::PH_MARK1: begin
            if (data == jfsp_pkg::MARKER_SOF0) begin
               parse_state = jfsp_pkg::PH_FRAME;
               field_pos   = jfsp_pkg::SOF_START;
            end else begin
               parse_state = jfsp_pkg::PH_LENHI;
            end
         end
         jfsp_pkg::PH_LENHI: begin
            length_word = {data, 8'h00};
            parse_state = jfsp_pkg::PH_LENLO;
         end
         jfsp_pkg::PH_LENLO: begin
            length_word = length_word | {8'h00, data};
            if (length_word < jfsp_pkg::SEG_MIN_LEN) begin
               bad = 1'b1;
            end else begin
               enter_skip(length_word - jfsp_pkg::SEG_MIN_LEN);
            end
         end
         jfsp_pkg::PH_FRAME: begin
            if (field_pos == jfsp_pkg::SOF_HEIGHT_HI) begin
               height_word = {data, 8'h00};
            end else if (field_pos == jfsp_pkg::SOF_HEIGHT_LO) begin
               height_word = height_word | {8'h00, data};
            end else if (field_pos == jfsp_pkg::SOF_WIDTH_HI) begin
               length_word = {data, 8'h00};
            end else if (field_pos >= jfsp_pkg::SOF_WIDTH_LO) begin
               width_word = length_word | {8'h00, data};
               found      = 1'b1;
            end
            if (!found) begin
               field_pos = field_pos + 4'd1;
            end
         end
         default: begin
         end
      endcase
      if (found || bad) begin
         file_decided = 1'b1;
         parse_state  = jfsp_pkg::PH_DONE;
         if (found) begin
            outcome.status = jfsp_pkg::STATUS_FOUND;
            outcome.height = height_word;
            outcome.width  = width_word;
         end else begin
            outcome.status = jfsp_pkg::STATUS_INVALID;
         end
         expected_sizes.push_back(outcome);
      end else if (last && !file_decided) begin
         outcome.status = jfsp_pkg::STATUS_NOT_FOUND;
         expected_sizes.push_back(outcome);
      end
      if (last) begin
         clear_parse_state();
      end
   endfunction

   function automatic logic [7:0] random_byte();
      logic [31:0] rnd;
      rnd = $urandom;
      return rnd[7:0];
   endfunction

   function automatic void put_random(input int count);
      repeat (count) file_bytes.push_back(random_byte());
   endfunction

   function automatic void put_header(input int app0_len);
      for (int i = 0; i < 11; i++) begin
         if (i == 4) begin
            file_bytes.push_back(app0_len[15:8]);
         end else if (i == 5) begin
            file_bytes.push_back(app0_len[7:0]);
         end else begin
            file_bytes.push_back(JFIF_PREFIX[87 - 8 * i -: 8]);
         end
      end
      if (app0_len >= int'(jfsp_pkg::APP0_MIN_LEN)) begin
         put_random(app0_len - int'(jfsp_pkg::APP0_MIN_LEN));
      end
   endfunction

   function automatic void put_segment(input logic [7:0] marker, input int seg_len);
      file_bytes.push_back(jfsp_pkg::MARKER_PREFIX);
      file_bytes.push_back(marker);
      file_bytes.push_back(seg_len[15:8]);
      file_bytes.push_back(seg_len[7:0]);
      if (seg_len >= int'(jfsp_pkg::SEG_MIN_LEN)) begin
         put_random(seg_len - int'(jfsp_pkg::SEG_MIN_LEN));
      end
   endfunction

   function automatic void put_frame(input int height, input int width);
      file_bytes.push_back(jfsp_pkg::MARKER_PREFIX);
      file_bytes.push_back(jfsp_pkg::MARKER_SOF0);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h11);
      file_bytes.push_back(8'h08);
      file_bytes.push_back(height[15:8]);
      file_bytes.push_back(height[7:0]);
      file_bytes.push_back(width[15:8]);
      file_bytes.push_back(width[7:0]);
   endfunction

   function automatic void truncate_file(input int keep);
      while (file_bytes.size() > keep) file_bytes.delete(file_bytes.size() - 1);
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.data_byte = data;
      req_bus.last_byte = last;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      predict_frame_size(data, last);
      bytes_sent++;
   endtask

   task automatic send_file();
      int count;
      count = file_bytes.size();
      for (int i = 0; i < count; i++) begin
         send_byte(file_bytes[i], i == count - 1);
      end
      file_bytes.delete();
   endtask

   task automatic finish_test();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_sizes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_frame_found();
      put_header(7);
      put_frame(65535, 65535);
      put_random(2);
      send_file();
      put_header(12);
      put_segment(MARKER_DQT, 6);
      put_segment(MARKER_DHT, 2);
      put_frame(0, 0);
      send_file();
      finish_test();
   endtask

   task automatic test_fill_bytes();
      put_header(7);
      put_segment(jfsp_pkg::MARKER_PREFIX, 4);
      put_frame(16'h1234, 16'h5678);
      put_random(1);
      send_file();
      finish_test();
   endtask

   task automatic test_bad_header();
      file_bytes.push_back(8'h00);
      send_file();
      put_header(6);
      put_frame(100, 200);
      send_file();
      put_header(0);
      put_frame(100, 200);
      send_file();
      put_header(7);
      file_bytes[6] = "j";
      put_frame(100, 200);
      send_file();
      finish_test();
   endtask

   task automatic test_bad_segment();
      put_header(7);
      put_segment(MARKER_DQT, 1);
      put_frame(1, 1);
      send_file();
      put_header(7);
      put_segment(MARKER_DQT, 0);
      send_file();
      put_header(7);
      file_bytes.push_back(8'h00);
      put_frame(1, 1);
      send_file();
      finish_test();
   endtask

   task automatic test_early_end();
      file_bytes.push_back(jfsp_pkg::MARKER_PREFIX);
      send_file();
      put_header(7);
      truncate_file(3);
      send_file();
      put_header(20);
      truncate_file(15);
      send_file();
      put_header(7);
      put_frame(16'hA5A5, 16'h5A5A);
      truncate_file(18);
      send_file();
      put_header(7);
      put_segment(MARKER_DQT, 4);
      send_file();
      finish_test();
   endtask

   task automatic test_long_segment();
      req_max_gap = 0;
      put_header(7);
      put_segment(MARKER_APP1, 258);
      put_frame($urandom_range(0, 65535), $urandom_range(0, 65535));
      send_file();
      req_max_gap = 4;
      finish_test();
   endtask

   // The receiver stalls on its own while single-byte files keep coming, so
   // the result register fills and the input side must stop taking bytes.
   task automatic test_backpressure();
      req_max_gap  = 0;
      hold_request = HOLD_CYCLES;
      repeat (24) begin
         file_bytes.push_back(($urandom_range(0, 1) == 0) ? jfsp_pkg::MARKER_PREFIX :
                              random_byte());
         send_file();
      end
      req_max_gap = 4;
      finish_test();
   endtask

   task automatic test_random_files();
      int start_bytes;
      int start_results;
      start_bytes   = bytes_sent;
      start_results = results_seen;
      while (bytes_sent - start_bytes < RANDOM_BYTES ||
             results_seen - start_results < RANDOM_RESULTS) begin
         req_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 4;
         rsp_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 4;
         if ($urandom_range(0, 11) == 0) begin
            put_header($urandom_range(0, 6));
         end else begin
            put_header(7 + $urandom_range(0, 6));
         end
         repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 11) == 0) begin
               put_segment(random_byte(), $urandom_range(0, 1));
            end else begin
               put_segment(random_byte(), $urandom_range(2, 8));
            end
         end
         put_frame($urandom_range(0, 65535), $urandom_range(0, 65535));
         put_random($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            5, 6, 9: truncate_file($urandom_range(1, file_bytes.size()));
            7: begin
               repeat ($urandom_range(1, 2)) begin
                  file_bytes[$urandom_range(0, file_bytes.size() - 1)] = random_byte();
               end
            end
            8: begin
               file_bytes.delete();
               put_random($urandom_range(1, 12));
            end
            default: begin
            end
         endcase
         send_file();
      end
      finish_test();
   endtask

   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_seen++;
         rsp_wait = $urandom_range(0, rsp_max_gap);
         if (expected_sizes.size() == 0) begin
            $error("unexpected result transfer: status %0d height %0d width %0d",
                   rsp_bus.status, rsp_bus.image_height, rsp_bus.image_width);
            error_count++;
         end else begin
            want = expected_sizes.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.image_height !== want.height) begin
               $error("image_height: expected %0d, actual %0d", want.height,
                      rsp_bus.image_height);
               error_count++;
            end
            if (rsp_bus.image_width !== want.width) begin
               $error("image_width: expected %0d, actual %0d", want.width,
                      rsp_bus.image_width);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready     = 1'b0;
      req_max_gap       = 4;
      rsp_max_gap       = 4;
      clear_parse_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_frame_found();
      test_fill_bytes();
      test_bad_header();
      test_bad_segment();
      test_early_end();
      test_long_segment();
      test_backpressure();
      test_random_files();

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
